>>> rtl/spifcs_pkg.sv
`default_nettype none

package spifcs_pkg;

	// defaults for the top-level parameters
	localparam int DEF_ADDRESS_BITS = 24;
	localparam int DEF_PAGE_BYTES   = 256;
	localparam int DEF_QUEUE_DEPTH  = 4;

	// fixed field widths
	localparam int OP_BITS      = 3;
	localparam int IN_ADDR_BITS = 24;
	localparam int BYTE_BITS    = 8;
	localparam int SEQ_IDX_BITS = 3;

	// host operation codes
	localparam logic [OP_BITS-1:0] OP_READ_START = 3'd0;
	localparam logic [OP_BITS-1:0] OP_READ_BYTE  = 3'd1;
	localparam logic [OP_BITS-1:0] OP_PROG_START = 3'd2;
	localparam logic [OP_BITS-1:0] OP_PROG_BYTE  = 3'd3;
	localparam logic [OP_BITS-1:0] OP_ERASE      = 3'd4;
	localparam logic [OP_BITS-1:0] OP_STATUS     = 3'd5;

	// flash command bytes
	localparam logic [BYTE_BITS-1:0] CMD_WREN  = 8'h06;
	localparam logic [BYTE_BITS-1:0] CMD_RDSR  = 8'h05;
	localparam logic [BYTE_BITS-1:0] CMD_READ  = 8'h03;
	localparam logic [BYTE_BITS-1:0] CMD_PP    = 8'h02;
	localparam logic [BYTE_BITS-1:0] CMD_SE    = 8'hd8;
	localparam logic [BYTE_BITS-1:0] DUMMY     = 8'h00;
	localparam int                   WIP_INDEX = 0;

	// work handed from the front end to the byte sequencer
	typedef enum logic [3:0] {
		K_READ_START = 4'd0,
		K_READ_BYTE  = 4'd1,
		K_PROG_START = 4'd2,
		K_PROG_MID   = 4'd3,
		K_PROG_END   = 4'd4,
		K_ERASE      = 4'd5,
		K_POLL       = 4'd6,
		K_DONE       = 4'd7,
		K_ERROR      = 4'd8
	} job_kind_t;

	typedef struct packed {
		job_kind_t                 kind;
		logic [IN_ADDR_BITS-1:0]   addr;
		logic [BYTE_BITS-1:0]      data;
		logic                      fin;
	} job_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] spi_byte;
		logic                 release_after;
		logic                 capture_read;
		logic                 no_transfer;
		logic                 op_done;
		logic                 order_error;
		logic                 last;
	} res_t;

	// index of the final result of each job kind
	function automatic logic [SEQ_IDX_BITS-1:0] job_last_idx(input job_kind_t kind);
		logic [SEQ_IDX_BITS-1:0] n;
		case (kind)
			K_READ_START: n = 3'd3;
			K_PROG_START: n = 3'd4;
			K_PROG_END:   n = 3'd2;
			K_ERASE:      n = 3'd6;
			K_POLL:       n = 3'd1;
			default:      n = 3'd0;
		endcase
		return n;
	endfunction

	// result number idx of a job
	function automatic res_t job_result(input job_t j, input logic [SEQ_IDX_BITS-1:0] idx);
		res_t r;
		r = '0;
		r.last = (idx == job_last_idx(j.kind));
		case (j.kind)
			K_READ_START: begin
				case (idx)
					3'd0:    r.spi_byte = CMD_READ;
					3'd1:    r.spi_byte = j.addr[23:16];
					3'd2:    r.spi_byte = j.addr[15:8];
					default: r.spi_byte = j.addr[7:0];
				endcase
			end
			K_READ_BYTE: begin
				r.spi_byte      = DUMMY;
				r.release_after = j.fin;
				r.capture_read  = 1'b1;
			end
			K_PROG_START: begin
				case (idx)
					3'd0: begin
						r.spi_byte      = CMD_WREN;
						r.release_after = 1'b1;
					end
					3'd1:    r.spi_byte = CMD_PP;
					3'd2:    r.spi_byte = j.addr[23:16];
					3'd3:    r.spi_byte = j.addr[15:8];
					default: r.spi_byte = j.addr[7:0];
				endcase
			end
			K_PROG_MID: begin
				r.spi_byte = j.data;
			end
			K_PROG_END: begin
				case (idx)
					3'd0: begin
						r.spi_byte      = j.data;
						r.release_after = 1'b1;
					end
					3'd1:    r.spi_byte = CMD_RDSR;
					default: begin
						r.spi_byte      = DUMMY;
						r.release_after = 1'b1;
					end
				endcase
			end
			K_ERASE: begin
				case (idx)
					3'd0: begin
						r.spi_byte      = CMD_WREN;
						r.release_after = 1'b1;
					end
					3'd1: r.spi_byte = CMD_SE;
					3'd2: r.spi_byte = j.addr[23:16];
					3'd3: r.spi_byte = j.addr[15:8];
					3'd4: begin
						r.spi_byte      = j.addr[7:0];
						r.release_after = 1'b1;
					end
					3'd5:    r.spi_byte = CMD_RDSR;
					default: begin
						r.spi_byte      = DUMMY;
						r.release_after = 1'b1;
					end
				endcase
			end
			K_POLL: begin
				case (idx)
					3'd0:    r.spi_byte = CMD_RDSR;
					default: begin
						r.spi_byte      = DUMMY;
						r.release_after = 1'b1;
					end
				endcase
			end
			K_DONE: begin
				r.no_transfer = 1'b1;
				r.op_done     = 1'b1;
			end
			default: begin
				r.no_transfer = 1'b1;
				r.order_error = 1'b1;
			end
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/spi_flash_command_sequencer.sv
// Serial NOR flash command sequencer. Each host item (read start, read byte, program
// start, program byte, sector erase, status reply) is accepted whenever the job
// queue has room, classified against the current mode and turned into one job; the
// byte sequencer behind the queue then emits that job's results at one per cycle
// while out_stall is low. An item has 1 to 7 results (e.g. 7 for an erase, 1 for a
// data byte). An accepted item is first written into the queue; with the sequencer
// free, its first result is then registered into the output register. The queue
// holds QUEUE_DEPTH jobs, so a burst of items is taken while earlier results still
// drain. Addresses wrap at 2^ADDRESS_BITS and only the low 24 bits are sent.
// PAGE_BYTES must be a power of two; chip select is released after each page
// and the status register polled until the write-in-progress bit clears.
`default_nettype none

module spi_flash_command_sequencer import spifcs_pkg::*; #(
	parameter int ADDRESS_BITS = DEF_ADDRESS_BITS,
	parameter int PAGE_BYTES   = DEF_PAGE_BYTES,
	parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [OP_BITS-1:0]      operation,
	input  wire logic [IN_ADDR_BITS-1:0] address,
	input  wire logic [BYTE_BITS-1:0]    data_byte,
	input  wire logic                    final_byte,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [BYTE_BITS-1:0]         spi_byte,
	output logic                         release_after,
	output logic                         capture_read,
	output logic                         no_transfer,
	output logic                         op_done,
	output logic                         order_error,
	output logic                         last
);

	logic push;
	job_t push_job;
	logic queue_full;
	logic pop;
	logic head_valid;
	job_t head_job;
	res_t result;

	// mode tracking and item classification
	spifcs_front #(
		.ADDRESS_BITS (ADDRESS_BITS),
		.PAGE_BYTES   (PAGE_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.address    (address),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.queue_full (queue_full),
		.push       (push),
		.job        (push_job)
	);

	// jobs waiting for the sequencer
	spifcs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// bus byte sequencer
	spifcs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result     (result)
	);

	assign spi_byte      = result.spi_byte;
	assign release_after = result.release_after;
	assign capture_read  = result.capture_read;
	assign no_transfer   = result.no_transfer;
	assign op_done       = result.op_done;
	assign order_error   = result.order_error;
	assign last          = result.last;

	// status-only results carry no bus byte
	a_status_only_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_transfer |-> spi_byte == '0 && !release_after && !capture_read && last)
		else $error("status-only result carries bus fields");

	// done and order error never come together
	a_done_vs_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(op_done && order_error))
		else $error("done and order error in one result");

	// read data capture only on a real bus byte that is the item's only result
	a_capture_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && capture_read |-> !no_transfer && last && spi_byte == '0)
		else $error("malformed read byte result");

endmodule

`default_nettype wire

>>> rtl/spifcs_front.sv
`default_nettype none

module spifcs_front import spifcs_pkg::*; #(
	parameter int ADDRESS_BITS = DEF_ADDRESS_BITS,
	parameter int PAGE_BYTES   = DEF_PAGE_BYTES
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [OP_BITS-1:0]      operation,
	input  wire logic [IN_ADDR_BITS-1:0] address,
	input  wire logic [BYTE_BITS-1:0]    data_byte,
	input  wire logic                    final_byte,
	input  wire logic                    queue_full,
	output logic                         push,
	output job_t                         job
);

	localparam int PAGE_BITS = $clog2(PAGE_BYTES);

	typedef enum logic [3:0] {
		M_IDLE = 4'b0001,
		M_READ = 4'b0010,
		M_PROG = 4'b0100,
		M_POLL = 4'b1000
	} mode_t;

	mode_t                   mode_q, mode_d;
	logic [ADDRESS_BITS-1:0] cur_addr_q, cur_addr_d;
	logic                    restart_q, restart_d;
	logic [ADDRESS_BITS-1:0] new_addr;
	logic [ADDRESS_BITS-1:0] next_addr;
	logic                    boundary;

	// accept whenever the queue has room
	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	assign new_addr  = ADDRESS_BITS'(address);
	assign next_addr = cur_addr_q + ADDRESS_BITS'(1);
	assign boundary  = (next_addr[PAGE_BITS-1:0] == '0);

	// classify the item against the current mode
	always_comb begin
		mode_d     = mode_q;
		cur_addr_d = cur_addr_q;
		restart_d  = restart_q;
		job.kind   = K_ERROR;
		job.addr   = IN_ADDR_BITS'(cur_addr_q);
		job.data   = data_byte;
		job.fin    = final_byte;
		case (operation)
			OP_READ_START: begin
				if (mode_q == M_IDLE) begin
					job.kind   = K_READ_START;
					job.addr   = IN_ADDR_BITS'(new_addr);
					cur_addr_d = new_addr;
					mode_d     = M_READ;
				end
			end
			OP_READ_BYTE: begin
				if (mode_q == M_READ) begin
					job.kind = K_READ_BYTE;
					if (final_byte) begin
						mode_d = M_IDLE;
					end
				end
			end
			OP_PROG_START: begin
				if (mode_q == M_IDLE) begin
					job.kind   = K_PROG_START;
					job.addr   = IN_ADDR_BITS'(new_addr);
					cur_addr_d = new_addr;
					mode_d     = M_PROG;
					restart_d  = 1'b0;
				end
			end
			OP_PROG_BYTE: begin
				if (mode_q == M_PROG) begin
					cur_addr_d = next_addr;
					if (final_byte || boundary) begin
						job.kind  = K_PROG_END;
						mode_d    = M_POLL;
						restart_d = !final_byte;
					end else begin
						job.kind = K_PROG_MID;
					end
				end
			end
			OP_ERASE: begin
				if (mode_q == M_IDLE) begin
					job.kind   = K_ERASE;
					job.addr   = IN_ADDR_BITS'(new_addr);
					cur_addr_d = new_addr;
					mode_d     = M_POLL;
					restart_d  = 1'b0;
				end
			end
			OP_STATUS: begin
				if (mode_q == M_POLL) begin
					if (data_byte[WIP_INDEX]) begin
						job.kind = K_POLL;
					end else if (restart_q) begin
						// resume programming at the next page
						job.kind  = K_PROG_START;
						mode_d    = M_PROG;
						restart_d = 1'b0;
					end else begin
						job.kind = K_DONE;
						mode_d   = M_IDLE;
					end
				end
			end
			default: begin
				job.kind = K_ERROR;
			end
		endcase
	end

	// state update on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_IDLE;
			cur_addr_q <= '0;
			restart_q  <= 1'b0;
		end else if (push) begin
			mode_q     <= mode_d;
			cur_addr_q <= cur_addr_d;
			restart_q  <= restart_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/spifcs_queue.sv
`default_nettype none

module spifcs_queue import spifcs_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_job,
	output logic      full,
	input  wire logic pop,
	output logic      head_valid,
	output job_t      head_job
);

	localparam int PTR_BITS = $clog2(DEPTH);
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	job_t                slot_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign full       = (count_q == CNT_BITS'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// job storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0
					: wr_ptr_q + PTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0
					: rd_ptr_q + PTR_BITS'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/spifcs_back.sv
`default_nettype none

module spifcs_back import spifcs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  job_t      head_job,
	output logic      pop,
	output logic      out_valid,
	input  wire logic out_stall,
	output res_t      result
);

	logic [SEQ_IDX_BITS-1:0] idx_q;
	logic                    out_valid_q;
	res_t                    out_q;
	res_t                    res;
	logic                    load;

	// one result of the head job per cycle into the output register while the output is not stalled
	assign res       = job_result(head_job, idx_q);
	assign load      = head_valid && (!out_valid_q || !out_stall);
	assign pop       = load && res.last;
	assign out_valid = out_valid_q;
	assign result    = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= res.last ? '0 : idx_q + SEQ_IDX_BITS'(1);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

endmodule

`default_nettype wire
